/* hdl/plb_pkg.sv */
// plb_pkg: shared types and codes for the price level book
// command codes, result status codes and sequencer states
// no dependencies
package plb_pkg;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int POS_BITS    = 6;

    // input command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_UPDATE      = 2'd0,
        CMD_READ_TOP    = 2'd1,
        CMD_READ_BOTTOM = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_UPDATED  = 3'd1,
        STAT_DELETED  = 3'd2,
        STAT_ABSENT   = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_READ_OK  = 3'd5,
        STAT_BAD_RANK = 3'd6
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_MATCH_WAIT,
        S_DECIDE,
        S_READ_WAIT,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESPOND
    } state_t;

endpackage

/* hdl/plb_if.sv */
// plb_if: valid/ready channel interfaces of the price level book
// request channel and result channel, each with source and sink modports
// no dependencies
interface plb_req_if #(
    parameter int PRICE_BITS  = 32,
    parameter int VOLUME_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [PRICE_BITS-1:0]  price;
    logic [VOLUME_BITS-1:0] volume;
    logic [5:0]             position;

    modport source (output valid, cmd, price, volume, position, input ready);
    modport sink   (input valid, cmd, price, volume, position, output ready);
endinterface

interface plb_rsp_if #(
    parameter int PRICE_BITS  = 32,
    parameter int VOLUME_BITS = 32,
    parameter int RANK_BITS   = 7,
    parameter int COUNT_BITS  = 7
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic [RANK_BITS-1:0]   rank;
    logic [PRICE_BITS-1:0]  level_price;
    logic [VOLUME_BITS-1:0] level_volume;
    logic [COUNT_BITS-1:0]  levels_held;

    modport source (output valid, status, rank, level_price, level_volume, levels_held,
                    input ready);
    modport sink   (input valid, status, rank, level_price, level_volume, levels_held,
                    output ready);
endinterface

/* hdl/plb_ram.sv */
// plb_ram: generic single write port, single read port RAM
// registered read data, no reset on the storage
// no dependencies
module plb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/price_level_book.sv */
// price_level_book: one side of an order book, levels sorted by descending price
// depends on plb_pkg, plb_if (plb_req_if, plb_rsp_if) and plb_ram
//
//  channel | dir | modport            | payload
//  req     | in  | plb_req_if.sink    | cmd, price, volume, position
//  rsp     | out | plb_rsp_if.source  | status, rank, level_price, level_volume,
//          |     |                    | levels_held
//
// one transaction in flight: req.ready is high only while the sequencer is idle
// read: decode, RAM read, result; bad rank or unused command: decode, result
// update: decode, the binary search steps (one RAM read each), a match read
// when the found rank is held, a decide step, then a read and a write for each
// level moved on insert or delete (one RAM port each)
// rsp holds its result until taken; rst_n clears the level count, no clearing pass
module price_level_book #(
    parameter int DEPTH       = 64,
    parameter int PRICE_BITS  = 32,
    parameter int VOLUME_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    plb_req_if.sink          req,
    plb_rsp_if.source        rsp
);
    import plb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam int DW = PRICE_BITS + VOLUME_BITS;

    // control state
    state_t              state_reg, state_next;
    logic   [CW-1:0]     count_reg, count_next;

    // working registers
    cmd_t                   cmd_reg, cmd_next;
    logic [PRICE_BITS-1:0]  price_reg, price_next;
    logic [VOLUME_BITS-1:0] volume_reg, volume_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic                   del_reg, del_next;
    logic                   match_reg, match_next;

    // result registers
    status_t                status_reg, status_next;
    logic [RW-1:0]          rank_reg, rank_next;
    logic [PRICE_BITS-1:0]  lp_reg, lp_next;
    logic [VOLUME_BITS-1:0] lv_reg, lv_next;

    // ram port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [PRICE_BITS-1:0]  rd_price;
    logic [VOLUME_BITS-1:0] rd_volume;
    logic [CW-1:0]          mid;
    logic [RW-1:0]          pos_ext;
    logic [RW-1:0]          count_ext;
    logic [RW-1:0]          read_idx;
    logic [CW-1:0]          start;

    plb_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_levels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // level fields out of the ram word
    assign rd_price  = ram_rdata[DW-1 -: PRICE_BITS];
    assign rd_volume = ram_rdata[VOLUME_BITS-1:0];

    // binary search midpoint, search start and read index
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_ext   = RW'(pos_reg);
    assign count_ext = RW'(count_reg);
    assign start     = (pos_ext > count_ext) ? count_reg : CW'(pos_reg);
    assign read_idx  = (cmd_reg == CMD_READ_TOP) ? pos_ext : (count_ext - RW'(1) - pos_ext);

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        price_reg  <= price_next;
        volume_reg <= volume_next;
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        cur_reg    <= cur_next;
        del_reg    <= del_next;
        match_reg  <= match_next;
        status_reg <= status_next;
        rank_reg   <= rank_next;
        lp_reg     <= lp_next;
        lv_reg     <= lv_next;
    end

    // sequencer: next state, ram control, result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        price_next  = price_reg;
        volume_next = volume_reg;
        pos_next    = pos_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cur_next    = cur_reg;
        del_next    = del_reg;
        match_next  = match_reg;
        status_next = status_reg;
        rank_next   = rank_reg;
        lp_next     = lp_reg;
        lv_next     = lv_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg[AW-1:0];
        ram_wdata   = {price_reg, volume_reg};
        ram_raddr   = mid[AW-1:0];
        req.ready   = 1'b0;
        rsp.valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next    = cmd_t'(req.cmd);
                    price_next  = req.price;
                    volume_next = req.volume;
                    pos_next    = req.position;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                lp_next = '0;
                lv_next = '0;
                unique case (cmd_reg)
                    CMD_UPDATE:
                    begin
                        lo_next    = start;
                        hi_next    = count_reg;
                        state_next = S_SEARCH;
                    end
                    CMD_READ_TOP, CMD_READ_BOTTOM:
                    begin
                        if (pos_ext < count_ext)
                        begin
                            ram_raddr  = read_idx[AW-1:0];
                            rank_next  = read_idx;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            status_next = STAT_BAD_RANK;
                            rank_next   = pos_ext;
                            state_next  = S_RESPOND;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_BAD_RANK;
                        rank_next   = '0;
                        state_next  = S_RESPOND;
                    end
                endcase
            end

            // one search step: fetch the midpoint level, or end the search at the found rank
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid[AW-1:0];
                    state_next = S_SEARCH_WAIT;
                end
                else
                begin
                    rank_next = RW'(lo_reg);
                    cur_next  = lo_reg;
                    if (lo_reg < count_reg)
                    begin
                        ram_raddr  = lo_reg[AW-1:0];
                        state_next = S_MATCH_WAIT;
                    end
                    else
                    begin
                        match_next = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end

            // narrow the range with the fetched price
            S_SEARCH_WAIT:
            begin
                if (price_reg < rd_price)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SEARCH;
            end

            S_MATCH_WAIT:
            begin
                match_next = (rd_price == price_reg);
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                priority if (match_reg && (volume_reg != '0))
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = cur_reg[AW-1:0];
                    status_next = STAT_UPDATED;
                    state_next  = S_RESPOND;
                end
                else if (match_reg)
                begin
                    del_next    = 1'b1;
                    status_next = STAT_DELETED;
                    state_next  = S_MOVE_RD;
                end
                else if (volume_reg == '0)
                begin
                    status_next = STAT_ABSENT;
                    state_next  = S_RESPOND;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    status_next = STAT_FULL;
                    state_next  = S_RESPOND;
                end
                else
                begin
                    del_next    = 1'b0;
                    cur_next    = count_reg;
                    status_next = STAT_INSERTED;
                    state_next  = S_MOVE_RD;
                end
            end

            S_READ_WAIT:
            begin
                status_next = STAT_READ_OK;
                lp_next     = rd_price;
                lv_next     = rd_volume;
                state_next  = S_RESPOND;
            end

            // shift one level: fetch the neighbor, or finish
            S_MOVE_RD:
            begin
                if (del_reg)
                begin
                    if ((cur_reg + CW'(1)) < count_reg)
                    begin
                        ram_raddr  = AW'(cur_reg + CW'(1));
                        state_next = S_MOVE_WR;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESPOND;
                    end
                end
                else
                begin
                    if (RW'(cur_reg) > rank_reg)
                    begin
                        ram_raddr  = AW'(cur_reg - CW'(1));
                        state_next = S_MOVE_WR;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = cur_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        state_next = S_RESPOND;
                    end
                end
            end

            // shift one level: store it one rank over
            S_MOVE_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                cur_next   = del_reg ? (cur_reg + CW'(1)) : (cur_reg - CW'(1));
                state_next = S_MOVE_RD;
            end

            S_RESPOND:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result payload
    assign rsp.status       = status_reg;
    assign rsp.rank         = rank_reg;
    assign rsp.level_price  = lp_reg;
    assign rsp.level_volume = lv_reg;
    assign rsp.levels_held  = count_reg;

    // level count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("level count beyond table depth");

    // level count only moves at the end of a shift
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_MOVE_RD))
        else $error("level count changed outside a shift");

    // never accept a new request while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted with result pending");

    // search range stays ordered and inside the table
    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> ((lo_reg <= hi_reg) && (hi_reg <= count_reg)))
        else $error("binary search range broken");

    // a successful read names a held rank
    a_read_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (status_reg == STAT_READ_OK)) |-> (rank_reg < count_ext))
        else $error("read result rank not held");

endmodule

/* tb/plb_book_checker.sv */
// plb_book_checker: watches the request and result channels of the price level book
// keeps its own copy of the level table, predicts each result and compares it
// depends on plb_pkg and plb_if (plb_req_if, plb_rsp_if)
module plb_book_checker #(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    plb_req_if   req,
    plb_rsp_if   rsp,
    output int   error_count,
    output int   pending_count
);
    import plb_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [6:0]  rank;
        logic [31:0] price;
        logic [31:0] volume;
        logic [6:0]  held;
    } level_result_t;

    // shadow of the level table, sorted by descending price
    logic [31:0] book_px  [DEPTH];
    logic [31:0] book_qty [DEPTH];
    int unsigned held_n = 0;

    level_result_t book_due [$];
    level_result_t seen;
    level_result_t want;
    int errs    = 0;
    int waiting = 0;

    assign error_count   = errs;
    assign pending_count = waiting;

    // apply one transaction to the shadow table and return its result
    function automatic level_result_t apply_order(logic [1:0] op, logic [31:0] px,
                                                  logic [31:0] qty, logic [5:0] pos);
        level_result_t r;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        int unsigned   k;
        r = '{st: STAT_BAD_RANK, rank: '0, price: '0, volume: '0, held: '0};
        if (op == CMD_UPDATE) begin
            // binary search for the first level at or below px, from the hint
            lo = (pos > held_n) ? held_n : pos;
            hi = held_n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (px < book_px[mid])
                    lo = mid + 1;
                else
                    hi = mid;
            end
            r.rank = lo[6:0];
            if (lo < held_n && book_px[lo] == px) begin
                if (qty != 0) begin
                    book_qty[lo] = qty;
                    r.st = STAT_UPDATED;
                end
                else begin
                    // remove the level, close the gap
                    for (k = lo; k + 1 < held_n; k++) begin
                        book_px[k]  = book_px[k + 1];
                        book_qty[k] = book_qty[k + 1];
                    end
                    held_n--;
                    r.st = STAT_DELETED;
                end
            end
            else if (qty == 0) begin
                r.st = STAT_ABSENT;
            end
            else if (held_n >= DEPTH) begin
                r.st = STAT_FULL;
            end
            else begin
                // open a slot at the found rank
                for (k = held_n; k > lo; k--) begin
                    book_px[k]  = book_px[k - 1];
                    book_qty[k] = book_qty[k - 1];
                end
                book_px[lo]  = px;
                book_qty[lo] = qty;
                held_n++;
                r.st = STAT_INSERTED;
            end
        end
        else if (op == CMD_READ_TOP || op == CMD_READ_BOTTOM) begin
            if (pos < held_n) begin
                k = (op == CMD_READ_TOP) ? pos : held_n - 1 - pos;
                r.st     = STAT_READ_OK;
                r.rank   = k[6:0];
                r.price  = book_px[k];
                r.volume = book_qty[k];
            end
            else begin
                r.rank = {1'b0, pos};
            end
        end
        r.held = held_n[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input bit orphan, input level_result_t exp_r,
                                   input level_result_t got_r);
        errs++;
        if (errs <= 10) begin
            if (orphan)
                $display("%0t: result with no transaction pending: status %0d rank %0d",
                         $realtime, got_r.st, got_r.rank);
            else begin
                $display("%0t: result mismatch: expected st %0d rank %0d px %h vol %h held %0d",
                         $realtime, exp_r.st, exp_r.rank, exp_r.price, exp_r.volume,
                         exp_r.held);
                $display("%0t:   got st %0d rank %0d px %h vol %h held %0d", $realtime,
                         got_r.st, got_r.rank, got_r.price, got_r.volume, got_r.held);
            end
        end
    endtask

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_n = 0;
            book_due.delete();
            waiting = 0;
        end
        else begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                book_due.push_back(apply_order(req.cmd, req.price, req.volume, req.position));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                seen = '{st: status_t'(rsp.status), rank: rsp.rank, price: rsp.level_price,
                         volume: rsp.level_volume, held: rsp.levels_held};
                if (book_due.size() == 0) begin
                    report_mismatch(1'b1, seen, seen);
                end
                else begin
                    want = book_due.pop_front();
                    if (seen.st !== want.st || seen.rank !== want.rank
                        || seen.price !== want.price || seen.volume !== want.volume
                        || seen.held !== want.held)
                        report_mismatch(1'b0, want, seen);
                end
            end
            waiting = book_due.size();
        end
    end

endmodule

/* tb/price_level_book_test.sv */
// price_level_book_test: stimulus, result taking and verdict for the price level book
// depends on plb_pkg, plb_if, price_level_book and plb_book_checker
module price_level_book_test;
    import plb_pkg::*;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          ITEM_TARGET = 1550;
    localparam longint      RUN_LIMIT   = 64'd12 * 64'd2_000_000;

    logic clk;
    logic rst_n;
    int   errs;
    int   pending;
    int   send_gap_pct = 13;
    int   take_gap_pct = 46;
    int   sent = 0;

    plb_req_if req_ch ();
    plb_rsp_if rsp_ch ();

    price_level_book u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    plb_book_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .error_count   (errs),
        .pending_count (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #(RUN_LIMIT);
        $display("price_level_book_test: done, errors");
        $finish;
    end

    // one request transaction, with random gaps ahead of it
    task automatic offer(input logic [1:0] op, input logic [31:0] px,
                         input logic [31:0] qty, input logic [5:0] pos);
        while ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.cmd      = op;
        req_ch.price    = px;
        req_ch.volume   = qty;
        req_ch.position = pos;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic [31:0] nonzero_volume();
        logic [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    // remove every price of a band, starting at a random point
    task automatic clear_band(input logic [31:0] base, input int step, input int count);
        int rot;
        int j;
        rot = $urandom_range(0, count - 1);
        for (j = 0; j < count; j++)
            offer(CMD_UPDATE, base + 32'((rot + j) % count * step), 32'd0, 6'd0);
    endtask

    // result side: random stalls and one long hold-off
    initial
    begin : take_results
        int taken;
        int hold_left;
        bit held_once;
        taken     = 0;
        hold_left = 0;
        held_once = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                taken++;
            @(negedge clk);
            if (taken >= 300 && !held_once) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else begin
                rsp_ch.ready = ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    // request side
    initial
    begin : make_orders
        int          episode;
        int          j;
        int          k;
        int          rot;
        int          pick;
        int          cap;
        logic [31:0] base;
        logic [31:0] qty;
        logic [5:0]  hint;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_UPDATE;
        req_ch.price    = '0;
        req_ch.volume   = '0;
        req_ch.position = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, hints, reads, deletes
        offer(CMD_READ_TOP,    32'd0,          32'd0,          6'd0);
        offer(CMD_READ_BOTTOM, 32'd0,          32'd0,          6'd63);
        offer(CMD_UNUSED,      32'hFFFF_FFFF,  32'hFFFF_FFFF,  6'd63);
        offer(CMD_UPDATE,      32'd1234,       32'd0,          6'd0);
        offer(CMD_UPDATE,      32'hFFFF_FFFF,  32'hFFFF_FFFF,  6'd0);
        // hint beyond the table saturates to the level count
        offer(CMD_UPDATE,      32'd0,          32'd1,          6'd63);
        offer(CMD_UPDATE,      32'd1000,       32'd5,          6'd0);
        offer(CMD_UPDATE,      32'd1000,       32'hA5A5_A5A5,  6'd1);
        offer(CMD_UPDATE,      32'd2000,       32'd9,          6'd0);
        offer(CMD_READ_TOP,    32'd0,          32'd0,          6'd0);
        offer(CMD_READ_TOP,    32'd0,          32'd0,          6'd3);
        offer(CMD_READ_TOP,    32'd0,          32'd0,          6'd4);
        offer(CMD_READ_BOTTOM, 32'd0,          32'd0,          6'd0);
        offer(CMD_READ_BOTTOM, 32'd0,          32'd0,          6'd3);
        offer(CMD_UPDATE,      32'd1500,       32'd0,          6'd0);
        offer(CMD_UPDATE,      32'd7,          32'd0,          6'd63);
        offer(CMD_UPDATE,      32'd1000,       32'd0,          6'd0);
        offer(CMD_UPDATE,      32'hFFFF_FFFF,  32'd0,          6'd0);
        offer(CMD_UPDATE,      32'd0,          32'd0,          6'd0);
        // hint past the level: wrong hint goes undetected
        offer(CMD_UPDATE,      32'd2000,       32'd0,          6'd5);
        offer(CMD_UPDATE,      32'd2000,       32'd0,          6'd0);

        // random episodes
        while (sent < ITEM_TARGET) begin
            if (sent < ITEM_TARGET / 3) begin
                send_gap_pct = 13;
                take_gap_pct = 46;
            end
            else if (sent < 2 * ITEM_TARGET / 3) begin
                send_gap_pct = 46;
                take_gap_pct = 13;
            end
            else begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            episode = $urandom_range(0, 9);
            if (episode < 5) begin
                // churn in a narrow band so updates and deletes hit
                base = $urandom_range(0, 32'hFFFF_FF00);
                for (j = 0; j < 40; j++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65) begin
                        qty  = ($urandom_range(0, 2) == 0) ? 32'd0 : nonzero_volume();
                        hint = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) : 6'd0;
                        offer(CMD_UPDATE, base + 32'($urandom_range(0, 23) * 3), qty, hint);
                    end
                    else if (pick < 95) begin
                        offer(($urandom_range(0, 1) == 0) ? CMD_READ_TOP : CMD_READ_BOTTOM,
                              $urandom, $urandom, 6'($urandom_range(0, 30)));
                    end
                    else begin
                        offer(CMD_UNUSED, $urandom, $urandom, 6'($urandom_range(0, 63)));
                    end
                end
                clear_band(base, 3, 24);
            end
            else if (episode < 7) begin
                // fill past capacity with distinct prices, then empty the band
                base = $urandom_range(0, 32'hFFFF_FE00);
                rot  = $urandom_range(0, 99);
                for (j = 0; j < 75; j++) begin
                    k = (rot + j * 37) % 100;
                    offer(CMD_UPDATE, base + 32'(k * 2), nonzero_volume(), 6'd0);
                    if (j % 8 == 7)
                        offer(($urandom_range(0, 1) == 0) ? CMD_READ_TOP : CMD_READ_BOTTOM,
                              32'd0, 32'd0, 6'($urandom_range(0, 63)));
                end
                cap = $urandom_range(2, 6);
                for (j = 0; j < cap; j++)
                    offer(CMD_UPDATE, base + 32'($urandom_range(0, 99) * 2),
                          nonzero_volume(), 6'd0);
                clear_band(base, 2, 100);
            end
            else begin
                // unstructured transactions over the whole field range
                for (j = 0; j < 15; j++) begin
                    qty = ($urandom_range(0, 9) == 0) ? $urandom : 32'd0;
                    offer(2'($urandom_range(0, 3)), $urandom, qty,
                          6'($urandom_range(0, 63)));
                end
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;

        // drain, then allow for the longest update
        for (j = 0; j < 50000 && pending != 0; j++)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errs == 0 && pending == 0)
            $display("price_level_book_test: done, clean");
        else
            $display("price_level_book_test: done, errors");
        $finish;
    end

endmodule

/* price_level_book.f */
hdl/plb_pkg.sv
hdl/plb_if.sv
hdl/plb_ram.sv
hdl/price_level_book.sv
tb/plb_book_checker.sv
tb/price_level_book_test.sv
